### sv/oets_pkg.sv
// Shared constants, types and node control codes for the odd-even transposition sorter.
// No dependencies; every other file uses this package.
package oets_pkg;

   localparam int MAX_ELEMS = 64;
   localparam int DATA_W    = 32;
   localparam int CNT_W     = $clog2(MAX_ELEMS + 1);

   typedef logic signed [DATA_W-1:0] value_type;
   typedef logic [CNT_W-1:0]         count_type;

   // Operation broadcast to every node in the chain.
   typedef enum logic [1:0] {
      OP_HOLD  = 2'd0,
      OP_LOAD  = 2'd1,
      OP_SORT  = 2'd2,
      OP_SHIFT = 2'd3
   } node_op_type;

   typedef struct packed {
      node_op_type op;
      logic        sel;        // this node takes the incoming beat
      logic        pair_left;  // node is the lower member of its pair this phase
      logic        pair_en;    // the pair lies inside the batch
   } node_ctl_type;

endpackage

### sv/oets_if.sv
// Valid/ready stream interfaces for the sorter's request and response channels.
// Depends on oets_pkg for the payload types.
interface oets_req_if;
   logic                 valid;
   logic                 ready;
   oets_pkg::value_type  value;
   logic                 last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

interface oets_rsp_if;
   logic                 valid;
   logic                 ready;
   oets_pkg::value_type  sorted_value;
   logic                 last_res;

   modport source (output valid, output sorted_value, output last_res, input ready);
   modport sink   (input valid, input sorted_value, input last_res, output ready);
endinterface

### sv/oets_node.sv
// One node of the sorting chain: holds a single element and trades it with a neighbor.
// Depends on oets_pkg.
module oets_node (
   input  logic                 clock,
   input  oets_pkg::node_ctl_type ctl,
   input  oets_pkg::value_type  load_value,
   input  oets_pkg::value_type  left_value,
   input  oets_pkg::value_type  right_value,
   output oets_pkg::value_type  value
);
   import oets_pkg::*;

   value_type value_ff;
   value_type value_in;

   always_comb begin
      value_in = value_ff;
      case (ctl.op)
         OP_HOLD: begin
            value_in = value_ff;
         end
         OP_LOAD: begin
            if (ctl.sel) begin
               value_in = load_value;
            end
         end
         OP_SORT: begin
            // lower member keeps the min, upper member keeps the max
            if (ctl.pair_en) begin
               if (ctl.pair_left) begin
                  if (right_value < value_ff) begin
                     value_in = right_value;
                  end
               end else if (left_value > value_ff) begin
                  value_in = left_value;
               end
            end
         end
         OP_SHIFT: begin
            value_in = right_value;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

### sv/odd_even_transposition_sort.sv
// Odd-even transposition sorter. A batch of N values (1..MAX_ELEMS) loads one beat per
// cycle while req.valid is high, sorts in N compare-exchange phases on the node chain,
// then drains one beat per cycle from node 0 while rsp.ready is high. The next batch
// loads after the last response beat. Reset (synchronous, active high) empties the
// batch and returns to loading; node contents are not cleared.
// Depends on oets_pkg, oets_if and oets_node.
module odd_even_transposition_sort (
   input  logic        clock,
   input  logic        reset,
   oets_req_if.sink    req,
   oets_rsp_if.source  rsp
);
   import oets_pkg::*;

   // one-hot controller states
   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_SORT = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   count_type   count_ff, count_in;   // elements held in the chain
   count_type   phase_ff, phase_in;   // sort phases left
   logic        parity_ff, parity_in; // 0: even pairs this phase

   node_op_type  op;
   node_ctl_type ctl [MAX_ELEMS];
   value_type    node_value [MAX_ELEMS];

   logic req_beat;
   logic rsp_beat;
   logic batch_end;

   assign req.ready = (state_ff == ST_LOAD);
   assign req_beat  = req.valid && req.ready;

   // the response comes straight from node 0's register
   assign rsp.valid        = (state_ff == ST_EMIT);
   assign rsp.sorted_value = node_value[0];
   assign rsp.last_res     = (count_ff == CNT_W'(1));
   assign rsp_beat         = rsp.valid && rsp.ready;

   // a full chain closes the batch as if the last flag were set
   assign batch_end = req.last || (count_ff == CNT_W'(MAX_ELEMS - 1));

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      phase_in  = phase_ff;
      parity_in = parity_ff;
      op        = OP_HOLD;
      case (state_ff)
         ST_LOAD: begin
            // append the beat at the end of the chain
            if (req_beat) begin
               op       = OP_LOAD;
               count_in = count_ff + CNT_W'(1);
               if (batch_end) begin
                  state_in  = ST_SORT;
                  phase_in  = count_ff + CNT_W'(1);
                  parity_in = 1'b0;
               end
            end
         end
         ST_SORT: begin
            // N alternating phases always leave N elements in order
            op        = OP_SORT;
            parity_in = ~parity_ff;
            phase_in  = phase_ff - CNT_W'(1);
            if (phase_ff == CNT_W'(1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // advance the chain toward node 0 on every response beat
            if (rsp_beat) begin
               op       = OP_SHIFT;
               count_in = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         count_ff  <= '0;
         phase_ff  <= '0;
         parity_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         phase_ff  <= phase_in;
         parity_ff <= parity_in;
      end
   end

   // node chain: node i pairs upward on phases of its own parity, downward otherwise
   for (genvar i = 0; i < MAX_ELEMS; i++) begin : g_node
      localparam logic Odd     = 1'(i % 2);
      localparam logic HasLeft = (i > 0);

      value_type left_value;
      value_type right_value;

      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_inner_l
         assign left_value = node_value[i-1];
      end

      if (i == MAX_ELEMS - 1) begin : g_final
         assign right_value = '0;
      end else begin : g_inner_r
         assign right_value = node_value[i+1];
      end

      assign ctl[i].op        = op;
      assign ctl[i].sel       = (count_ff == CNT_W'(i));
      assign ctl[i].pair_left = (Odd == parity_ff);
      assign ctl[i].pair_en   = ctl[i].pair_left ? (count_ff > CNT_W'(i + 1))
                                                 : (HasLeft && (count_ff > CNT_W'(i)));

      oets_node u_node (
         .clock       (clock),
         .ctl         (ctl[i]),
         .load_value  (req.value),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (node_value[i])
      );
   end

endmodule

### sv/oets_checker.sv
// Port-level checks for the odd-even transposition sorter, bound to the top level.
// Depends on oets_pkg and odd_even_transposition_sort.
module oets_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input oets_pkg::value_type rsp_sorted_value,
   input logic                rsp_last_res
);
   import oets_pkg::*;

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sorted_value)
                                  && $stable(rsp_last_res))
      else $error("response changed while stalled");

   // loading and draining never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request and response active together");

   // the final beat of a batch reopens loading
   a_reopen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_res |=> req_ready && !rsp_valid)
      else $error("batch end did not return to loading");

   // back-to-back beats of one batch come out in ascending order
   a_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && $past(rsp_valid && rsp_ready && !rsp_last_res)
      |-> $past(rsp_sorted_value) <= rsp_sorted_value)
      else $error("response beats out of order");

endmodule

bind odd_even_transposition_sort oets_checker u_oets_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_sorted_value (rsp.sorted_value),
   .rsp_last_res     (rsp.last_res)
);
